// ----- src/lzw_byte_encoder_unit_macros.svh -----
// Assertion helpers for the LZW byte encoder checker.
`ifndef LZW_BYTE_ENCODER_UNIT_MACROS_SVH
`define LZW_BYTE_ENCODER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while in reset.
`define LBE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while in reset.
`define LBE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/lbe_pkg.sv -----
package lbe_pkg;

  localparam int CODE_BITS  = 12;
  localparam int DICT_DEPTH = 3840;
  localparam int DICT_AW    = $clog2(DICT_DEPTH);
  localparam int SLOT_BITS  = CODE_BITS;
  localparam int SLOT_COUNT = 1 << SLOT_BITS;
  localparam int KEY_BITS   = CODE_BITS + 8;
  localparam int NEXT_BITS  = CODE_BITS + 1;

  localparam int FIRST_INT  = 256;
  localparam int LIMIT_INT  = ((FIRST_INT + DICT_DEPTH) < (1 << CODE_BITS)) ?
                              (FIRST_INT + DICT_DEPTH) : (1 << CODE_BITS);

  localparam logic [NEXT_BITS-1:0] FIRST_CODE = NEXT_BITS'(FIRST_INT);
  localparam logic [NEXT_BITS-1:0] CODE_LIMIT = NEXT_BITS'(LIMIT_INT);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic [CODE_BITS-1:0] code;
    logic                 end_of_stream;
  } out_t;

  typedef struct packed {
    logic [SLOT_BITS-1:0] slot;
    logic [KEY_BITS-1:0]  key;
  } dict_ent_t;

  typedef struct packed {
    logic                 en;
    logic [SLOT_BITS-1:0] addr;
    logic [CODE_BITS-1:0] data;
  } slot_wr_t;

  typedef struct packed {
    logic               en;
    logic [DICT_AW-1:0] addr;
    dict_ent_t          data;
  } dict_wr_t;

  function automatic logic [SLOT_BITS-1:0] slot_hash(input logic [CODE_BITS-1:0] prefix,
                                                     input logic [7:0] data_byte);
    logic [SLOT_BITS-1:0] mix;
    mix = SLOT_BITS'({data_byte, 4'h0}) ^ SLOT_BITS'({data_byte[3:0], data_byte[7:4]});
    return SLOT_BITS'(prefix) ^ mix;
  endfunction

endpackage

// ----- src/lbe_slot_ram.sv -----
// Hash table: slot -> code. An entry counts only if the dictionary points back to it.
module lbe_slot_ram (
  input  logic                          clk_i,
  input  logic [lbe_pkg::SLOT_BITS-1:0] rd_addr_i,
  input  lbe_pkg::slot_wr_t             wr_i,
  output logic [lbe_pkg::CODE_BITS-1:0] rd_data_o
);

  logic [lbe_pkg::CODE_BITS-1:0] mem_q [lbe_pkg::SLOT_COUNT];

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    rd_data_o <= mem_q[rd_addr_i];
  end

endmodule

// ----- src/lbe_dict_ram.sv -----
// Dictionary: code - 256 -> (owning slot, prefix code, byte).
module lbe_dict_ram (
  input  logic                        clk_i,
  input  logic [lbe_pkg::DICT_AW-1:0] rd_addr_i,
  input  lbe_pkg::dict_wr_t           wr_i,
  output lbe_pkg::dict_ent_t          rd_data_o
);

  lbe_pkg::dict_ent_t mem_q [lbe_pkg::DICT_DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    rd_data_o <= mem_q[rd_addr_i];
  end

endmodule

// ----- src/lbe_out_buf.sv -----
// Two-entry result queue; takes up to two results per cycle.
module lbe_out_buf (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [1:0]    push_n_i,
  input  lbe_pkg::out_t push0_i,
  input  lbe_pkg::out_t push1_i,
  output logic [1:0]    free_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output lbe_pkg::out_t out_data_o
);

  lbe_pkg::out_t ent_q [2];
  lbe_pkg::out_t ent_d [2];
  logic [1:0]    cnt_q, cnt_d;
  logic [1:0]    base;

  always_comb begin
    ent_d = ent_q;
    base  = cnt_q;
    if (out_valid_o && out_ready_i) begin
      ent_d[0] = ent_q[1];
      base     = cnt_q - 2'd1;
    end
    if (push_n_i != 2'd0) begin
      ent_d[base[0]] = push0_i;
    end
    if (push_n_i == 2'd2) begin
      ent_d[1] = push1_i;
    end
    cnt_d = base + push_n_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign free_o      = 2'd2 - cnt_q;
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = ent_q[0];

endmodule

// ----- src/lzw_byte_encoder_unit.sv -----
// Channel  | Direction | Signals
// in       | input     | in_valid_i / in_ready_o / in_data_i (data_byte, last_byte)
// out      | output    | out_valid_o / out_ready_i / out_data_o (code, end_of_stream)
// cfg      | input     | cfg_valid_i / cfg_ready_o / cfg_data_i (max_code)
//
// After reset all 4096 hash table slots are swept to empty, with in_ready_o low.
// A byte goes through ST_RDA and ST_CHKA per hash probe, plus ST_CHKB unless the slot is empty,
// then ST_DONE; the first byte of a stream goes straight to ST_DONE. Each probe reads the hash
// table, then the dictionary entry it points to; the probe count grows with hash collisions.
// Results sit in a two-entry queue; while it lacks room for them, the item is held in ST_DONE.
// The next byte is taken only after the current one has queued its results.
module lzw_byte_encoder_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  lbe_pkg::in_t                  in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output lbe_pkg::out_t                 out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [lbe_pkg::CODE_BITS-1:0] cfg_data_i
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_RDA   = 3'd2;
  localparam logic [2:0] ST_CHKA  = 3'd3;
  localparam logic [2:0] ST_CHKB  = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  localparam int CB = lbe_pkg::CODE_BITS;
  localparam int NB = lbe_pkg::NEXT_BITS;
  localparam int SB = lbe_pkg::SLOT_BITS;

  logic [2:0]    st_q, st_d;
  logic [SB-1:0] slot_q, slot_d, clr_q, clr_d;
  logic [7:0]    byte_q, byte_d;
  logic          last_q, last_d;
  logic [CB-1:0] prefix_q, prefix_d, cand_q, cand_d, max_q;
  logic          pvalid_q, pvalid_d;
  logic [NB-1:0] next_q, next_d;
  logic [1:0]    pend_n_q, pend_n_d, push_n, free;
  lbe_pkg::out_t pend0_q, pend0_d, pend1_q, pend1_d;

  lbe_pkg::slot_wr_t             a_wr;
  lbe_pkg::dict_wr_t             b_wr;
  logic [CB-1:0]                 a_rdata;
  lbe_pkg::dict_ent_t            b_rdata;
  logic [lbe_pkg::DICT_AW-1:0]   b_raddr;
  logic                          accept, do_hit, do_miss, grow;
  logic                          in_range;

  assign accept      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign in_range    = (NB'(a_rdata) >= lbe_pkg::FIRST_CODE) && (NB'(a_rdata) < next_q);
  assign b_raddr     = lbe_pkg::DICT_AW'(NB'(a_rdata) - lbe_pkg::FIRST_CODE);
  assign grow        = (next_q <= NB'(max_q)) && (next_q < lbe_pkg::CODE_LIMIT);

  always_comb begin
    st_d       = st_q;
    slot_d     = slot_q;
    clr_d      = clr_q;
    byte_d     = byte_q;
    last_d     = last_q;
    prefix_d   = prefix_q;
    cand_d     = cand_q;
    pvalid_d   = pvalid_q;
    next_d     = next_q;
    pend_n_d   = pend_n_q;
    pend0_d    = pend0_q;
    pend1_d    = pend1_q;
    a_wr       = '0;
    b_wr       = '0;
    in_ready_o = 1'b0;
    push_n     = 2'd0;
    do_hit     = 1'b0;
    do_miss    = 1'b0;

    case (st_q)
      ST_CLEAR: begin
        a_wr.en   = 1'b1;
        a_wr.addr = clr_q;
        clr_d     = clr_q + SB'(1);
        if (&clr_q) begin
          st_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (accept) begin
          byte_d = in_data_i.data_byte;
          last_d = in_data_i.last_byte;
          slot_d = lbe_pkg::slot_hash(prefix_q, in_data_i.data_byte);
          if (!pvalid_q) begin
            pend_n_d = 2'd0;
            prefix_d = CB'(in_data_i.data_byte);
            pvalid_d = 1'b1;
            if (in_data_i.last_byte) begin
              pend0_d  = '{code: CB'(in_data_i.data_byte), end_of_stream: 1'b1};
              pend_n_d = 2'd1;
              prefix_d = '0;
              pvalid_d = 1'b0;
              next_d   = lbe_pkg::FIRST_CODE;
            end
            st_d = ST_DONE;
          end else begin
            st_d = ST_RDA;
          end
        end
      end
      ST_RDA: begin
        st_d = ST_CHKA;
      end
      ST_CHKA: begin
        cand_d = a_rdata;
        if (in_range) begin
          st_d = ST_CHKB;
        end else begin
          do_miss = 1'b1;
        end
      end
      ST_CHKB: begin
        if (b_rdata.slot == slot_q) begin
          if (b_rdata.key == {prefix_q, byte_q}) begin
            do_hit = 1'b1;
          end else begin
            // probe the next slot
            slot_d = slot_q + SB'(1);
            st_d   = ST_RDA;
          end
        end else begin
          do_miss = 1'b1;
        end
      end
      ST_DONE: begin
        if (pend_n_q <= free) begin
          push_n = pend_n_q;
          st_d   = ST_IDLE;
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase

    if (do_miss) begin
      pend0_d  = '{code: prefix_q, end_of_stream: 1'b0};
      pend_n_d = 2'd1;
      if (grow) begin
        a_wr.en        = 1'b1;
        a_wr.addr      = slot_q;
        a_wr.data      = CB'(next_q);
        b_wr.en        = 1'b1;
        b_wr.addr      = lbe_pkg::DICT_AW'(next_q - lbe_pkg::FIRST_CODE);
        b_wr.data.slot = slot_q;
        b_wr.data.key  = {prefix_q, byte_q};
        next_d         = next_q + NB'(1);
      end
      prefix_d = CB'(byte_q);
      if (last_q) begin
        pend1_d  = '{code: CB'(byte_q), end_of_stream: 1'b1};
        pend_n_d = 2'd2;
        prefix_d = '0;
        pvalid_d = 1'b0;
        next_d   = lbe_pkg::FIRST_CODE;
      end
      st_d = ST_DONE;
    end

    if (do_hit) begin
      prefix_d = cand_q;
      pend_n_d = 2'd0;
      if (last_q) begin
        pend0_d  = '{code: cand_q, end_of_stream: 1'b1};
        pend_n_d = 2'd1;
        prefix_d = '0;
        pvalid_d = 1'b0;
        next_d   = lbe_pkg::FIRST_CODE;
      end
      st_d = ST_DONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= ST_CLEAR;
      clr_q    <= '0;
      prefix_q <= '0;
      pvalid_q <= 1'b0;
      next_q   <= lbe_pkg::FIRST_CODE;
      max_q    <= '1;
      pend_n_q <= 2'd0;
    end else begin
      st_q     <= st_d;
      clr_q    <= clr_d;
      prefix_q <= prefix_d;
      pvalid_q <= pvalid_d;
      next_q   <= next_d;
      pend_n_q <= pend_n_d;
      if (cfg_valid_i && cfg_ready_o) begin
        max_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q  <= slot_d;
    byte_q  <= byte_d;
    last_q  <= last_d;
    cand_q  <= cand_d;
    pend0_q <= pend0_d;
    pend1_q <= pend1_d;
  end

  lbe_slot_ram u_slot_ram (
    .clk_i     (clk_i),
    .rd_addr_i (slot_q),
    .wr_i      (a_wr),
    .rd_data_o (a_rdata)
  );

  lbe_dict_ram u_dict_ram (
    .clk_i     (clk_i),
    .rd_addr_i (b_raddr),
    .wr_i      (b_wr),
    .rd_data_o (b_rdata)
  );

  lbe_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_n_i    (push_n),
    .push0_i     (pend0_q),
    .push1_i     (pend1_q),
    .free_o      (free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- src/lbe_checker.sv -----
`include "lzw_byte_encoder_unit_macros.svh"

module lbe_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input lbe_pkg::out_t                 out_data_o,
  input logic                          cfg_valid_i,
  input logic                          cfg_ready_o
);

  `LBE_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o, "result dropped")
  `LBE_ASSERT_NEXT(a_out_stable, out_valid_o && !out_ready_i, $stable(out_data_o), "result changed")
  `LBE_ASSERT_NEXT(a_one_item, in_valid_i && in_ready_o, !in_ready_o, "second byte taken early")
  `LBE_ASSERT_NOW(a_cfg_open, cfg_valid_i, cfg_ready_o, "config write refused")

endmodule

bind lzw_byte_encoder_unit lbe_checker u_lbe_checker (.*);
